// ===== rtl/core/mean_curvature_blur_pass_core_defines.svh =====
// Assertion macros shared by the checker of the blur pass core.
// Depends on a clock named clk and a synchronous reset named rst in scope.
`ifndef MEAN_CURVATURE_BLUR_PASS_CORE_DEFINES_SVH
`define MEAN_CURVATURE_BLUR_PASS_CORE_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define MCB_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle port check failed");

// Antecedent implies consequent in the following cycle.
`define MCB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle port check failed");

`endif

// ===== rtl/core/mcb_pkg.sv =====
`timescale 1ns / 1ps
// Types and constants of the mean curvature blur pass core.
// No dependencies.
package mcb_pkg;

  localparam int unsigned NUM_W = 102;
  localparam int unsigned DEN_W = 70;
  localparam int unsigned Q_W   = 41;
  localparam int unsigned CMP_W = DEN_W + Q_W;

  localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam logic [10:0] FRAME_WIDTH_RESET   = 11'd1024;
  localparam logic [10:0] FRAME_HEIGHT_RESET  = 11'd1024;
  localparam logic [2:0]  CHANNEL_COUNT_RESET = 3'd1;

  typedef struct packed {
    logic signed [31:0] top;
    logic signed [31:0] mid;
    logic signed [31:0] bot;
  } tri_t;

  typedef struct packed {
    logic               last;
    logic               flat;
    logic signed [31:0] centre;
  } side_t;

  typedef struct packed {
    logic               valid;
    logic               last;
    logic               flat;
    logic               neg;
    logic               ov;
    logic signed [31:0] centre;
    logic [Q_W-1:0]     quo;
    logic [NUM_W-1:0]   rem;
    logic [DEN_W-1:0]   den;
  } div_bus_t;

  typedef struct packed {
    logic               last;
    logic signed [31:0] value;
  } res_t;

endpackage

// ===== rtl/core/mcb_lines.sv =====
`timescale 1ns / 1ps
// Upper and middle line stores: two synchronous memories, one read port each.
// Standalone, no package needed.
module mcb_lines #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [31:0]              wr_upper,
  input  logic [31:0]              wr_middle,
  output logic [31:0]              rd_upper,
  output logic [31:0]              rd_middle
);

  logic [31:0] upper_mem  [DEPTH];
  logic [31:0] middle_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= wr_upper;
      middle_mem[wr_addr] <= wr_middle;
    end
    if (rd_en) begin
      rd_upper  <= upper_mem[rd_addr];
      rd_middle <= middle_mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/mcb_div_step.sv =====
`timescale 1ns / 1ps
// One restoring division step that resolves a single quotient bit.
// Depends on mcb_pkg for the divider bus type and widths.
module mcb_div_step #(
  parameter int unsigned BIT = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  mcb_pkg::div_bus_t din,
  output mcb_pkg::div_bus_t dout
);
  import mcb_pkg::*;

  logic [CMP_W-1:0] shifted;
  logic [CMP_W-1:0] rem_ext;
  logic             ge;
  div_bus_t         nxt;

  always_comb begin
    shifted = CMP_W'(din.den) << BIT;
    rem_ext = CMP_W'(din.rem);
    ge      = rem_ext >= shifted;
    nxt     = din;
    if (ge) begin
      nxt.rem = NUM_W'(rem_ext - shifted);
      nxt.quo = din.quo | (Q_W'(1) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (adv) begin
      dout <= nxt;
    end
  end

endmodule

// ===== rtl/core/mcb_skid.sv =====
`timescale 1ns / 1ps
// Output register with a one-entry skid buffer behind it.
// Depends on mcb_pkg for the result type.
module mcb_skid (
  input  logic         clk,
  input  logic         rst,
  input  logic         pipe_valid,
  input  mcb_pkg::res_t pipe_data,
  output logic         skid_full,
  output logic         out_valid,
  output mcb_pkg::res_t out_data,
  input  logic         out_ready
);
  import mcb_pkg::*;

  res_t skid_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_full) begin
        out_data  <= skid_data;
        out_valid <= 1'b1;
        skid_full <= 1'b0;
      end else begin
        out_data  <= pipe_data;
        out_valid <= pipe_valid;
      end
    end else if (pipe_valid && !skid_full) begin
      skid_data <= pipe_data;
      skid_full <= 1'b1;
    end
  end

endmodule

// ===== rtl/core/mean_curvature_blur_pass_core.sv =====
`timescale 1ns / 1ps
// Mean curvature blur, one pass, on a streamed border-padded image.
// Depends on mcb_pkg, mcb_lines, mcb_div_step and mcb_skid.
//
// Samples enter on in_valid/in_ready in raster order, channels interleaved,
// one channel sample per item. Each interior sample yields one item on
// out_valid/out_ready; border samples yield none. last_of_frame marks the
// final interior sample of a frame. Frame size and channel count are set
// over the APB port; the user must set them only while the block is idle,
// which the block itself does not enforce. Any write restarts the frame.
// One item is accepted per cycle while in_ready is high. The item completing
// a window passes the line store read, nine arithmetic stages, one overflow
// compare, 41 divider steps, one per quotient bit, and the output register.
// Reset clears the frame position, the pipeline and the output; line store
// contents stay undefined until written. When the receiver stalls, one
// result is caught in a skid register and in_ready then drops until the
// output drains, freezing the whole pipeline.
module mean_curvature_blur_pass_core #(
  parameter int unsigned MAX_WIDTH    = 1024,
  parameter int unsigned MAX_HEIGHT   = 1024,
  parameter int unsigned MAX_CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [31:0] sample_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] filtered_value,
  output logic        last_of_frame
);
  import mcb_pkg::*;

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned XW    = $clog2(MAX_WIDTH);
  localparam int unsigned YW    = $clog2(MAX_HEIGHT);
  localparam int unsigned CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned HD    = 2 * MAX_CHANNELS;
  localparam int unsigned LW    = $clog2(HD);

  logic [10:0] frame_width;
  logic [10:0] frame_height;
  logic [2:0]  channel_count;
  logic        cfg_wr;

  logic [XW-1:0] wm1;
  logic [YW-1:0] hm1;
  logic [CW-1:0] cnm1;

  logic [CW-1:0] chan;
  logic [XW-1:0] xpos;
  logic [YW-1:0] row;
  logic [AW-1:0] col;

  logic adv;
  logic accept;
  logic skid_full;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign adv      = !skid_full;
  assign in_ready = adv;
  assign accept   = in_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= FRAME_WIDTH_RESET;
      frame_height  <= FRAME_HEIGHT_RESET;
      channel_count <= CHANNEL_COUNT_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_FRAME_WIDTH:   frame_width   <= pwdata[10:0];
        REG_FRAME_HEIGHT:  frame_height  <= pwdata[10:0];
        REG_CHANNEL_COUNT: channel_count <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FRAME_WIDTH:   prdata = {21'd0, frame_width};
      REG_FRAME_HEIGHT:  prdata = {21'd0, frame_height};
      REG_CHANNEL_COUNT: prdata = {29'd0, channel_count};
      default:           prdata = 32'd0;
    endcase
  end

  always_comb begin
    if (frame_width < 11'd3) begin
      wm1 = XW'(2);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      wm1 = XW'(MAX_WIDTH - 1);
    end else begin
      wm1 = XW'(frame_width - 11'd1);
    end
    if (frame_height < 11'd3) begin
      hm1 = YW'(2);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      hm1 = YW'(MAX_HEIGHT - 1);
    end else begin
      hm1 = YW'(frame_height - 11'd1);
    end
    if (channel_count == 3'd0) begin
      cnm1 = '0;
    end else if (32'(channel_count) > MAX_CHANNELS) begin
      cnm1 = CW'(MAX_CHANNELS - 1);
    end else begin
      cnm1 = CW'(channel_count - 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      chan <= '0;
      xpos <= '0;
      row  <= '0;
      col  <= '0;
    end else if (accept) begin
      if (chan == cnm1) begin
        chan <= '0;
        if (xpos == wm1) begin
          xpos <= '0;
          col  <= '0;
          row  <= (row == hm1) ? '0 : row + YW'(1);
        end else begin
          xpos <= xpos + XW'(1);
          col  <= col + AW'(1);
        end
      end else begin
        chan <= chan + CW'(1);
        col  <= col + AW'(1);
      end
    end
  end

  // Stage 1: line store read returns; window history supplies older columns.
  logic               v1;
  logic               emit1;
  logic               last1;
  logic [AW-1:0]      addr1;
  logic signed [31:0] bot1;
  logic [31:0]        rd_upper;
  logic [31:0]        rd_middle;
  tri_t               hist [HD];
  tri_t               cur1;
  tri_t               tap_new;
  tri_t               tap_old;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bot1  <= sample_value;
      addr1 <= col;
      emit1 <= (row >= YW'(2)) && (xpos >= XW'(2));
      last1 <= (row == hm1) && (xpos == wm1) && (chan == cnm1);
    end
  end

  mcb_lines #(.DEPTH(DEPTH)) u_lines (
    .clk       (clk),
    .rd_en     (accept),
    .rd_addr   (col),
    .wr_en     (v1 && adv),
    .wr_addr   (addr1),
    .wr_upper  (rd_middle),
    .wr_middle (bot1),
    .rd_upper  (rd_upper),
    .rd_middle (rd_middle)
  );

  assign cur1    = '{top: rd_upper, mid: rd_middle, bot: bot1};
  assign tap_new = hist[LW'(cnm1)];
  assign tap_old = hist[LW'({cnm1, 1'b1})];

  always_ff @(posedge clk) begin
    if (v1 && adv) begin
      hist[0] <= cur1;
      for (int i = 1; i < HD; i++) begin
        hist[i] <= hist[i-1];
      end
    end
  end

  // Stage 2: first and second differences.
  logic               v2;
  logic signed [32:0] dx2r;
  logic signed [32:0] dy2r;
  logic signed [34:0] dxx2;
  logic signed [34:0] dyy2;
  logic signed [34:0] sxy2;
  logic signed [31:0] c2;
  logic               last2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1 && emit1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx2r  <= {cur1.mid[31], cur1.mid} - {tap_old.mid[31], tap_old.mid};
      dy2r  <= {tap_new.bot[31], tap_new.bot} - {tap_new.top[31], tap_new.top};
      dxx2  <= {{3{cur1.mid[31]}}, cur1.mid} + {{3{tap_old.mid[31]}}, tap_old.mid}
               - {{2{tap_new.mid[31]}}, tap_new.mid, 1'b0};
      dyy2  <= {{3{tap_new.bot[31]}}, tap_new.bot} + {{3{tap_new.top[31]}}, tap_new.top}
               - {{2{tap_new.mid[31]}}, tap_new.mid, 1'b0};
      sxy2  <= {{3{cur1.bot[31]}}, cur1.bot} - {{3{cur1.top[31]}}, cur1.top}
               - {{3{tap_old.bot[31]}}, tap_old.bot} + {{3{tap_old.top[31]}}, tap_old.top};
      c2    <= tap_new.mid;
      last2 <= last1;
    end
  end

  // Stage 3: magnitudes and term signs.
  logic        v3;
  logic [32:0] ax3;
  logic [32:0] ay3;
  logic [35:0] m1_3;
  logic [35:0] m2_3;
  logic [34:0] m3_3;
  logic [2:0]  neg3;
  side_t       side3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax3     <= dx2r[32] ? (~dx2r + 33'd1) : dx2r;
      ay3     <= dy2r[32] ? (~dy2r + 33'd1) : dy2r;
      m1_3    <= {(dyy2[34] ? (~dyy2 + 35'd1) : dyy2), 1'b0};
      m2_3    <= {(dxx2[34] ? (~dxx2 + 35'd1) : dxx2), 1'b0};
      m3_3    <= sxy2[34] ? (~sxy2 + 35'd1) : sxy2;
      neg3[0] <= dyy2[34];
      neg3[1] <= dxx2[34];
      neg3[2] <= !(dx2r[32] ^ dy2r[32] ^ sxy2[34]);
      side3   <= '{last: last2, flat: (dx2r == '0) && (dy2r == '0), centre: c2};
    end
  end

  // Stage 4: squares and cross product of the gradient.
  logic        v4;
  logic [65:0] sx4;
  logic [65:0] sy4;
  logic [65:0] sxy4;
  logic [35:0] m1_4;
  logic [35:0] m2_4;
  logic [34:0] m3_4;
  logic [2:0]  neg4;
  side_t       side4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sx4   <= ax3 * ax3;
      sy4   <= ay3 * ay3;
      sxy4  <= ax3 * ay3;
      m1_4  <= m1_3;
      m2_4  <= m2_3;
      m3_4  <= m3_3;
      neg4  <= neg3;
      side4 <= side3;
    end
  end

  // Stage 5: partial products of the numerator terms, and the denominator.
  logic             v5;
  logic [68:0]      p1l, p1h, p2l, p2h, p3l, p3h;
  logic [DEN_W-1:0] den5;
  logic [2:0]       neg5;
  side_t            side5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1l   <= sx4[32:0] * m1_4;
      p1h   <= sx4[65:33] * m1_4;
      p2l   <= sy4[32:0] * m2_4;
      p2h   <= sy4[65:33] * m2_4;
      p3l   <= sxy4[32:0] * m3_4;
      p3h   <= sxy4[65:33] * m3_4;
      den5  <= {67'(sx4) + 67'(sy4), 3'b000};
      neg5  <= neg4;
      side5 <= side4;
    end
  end

  // Stage 6: assemble the three term magnitudes.
  logic             v6;
  logic [NUM_W-1:0] t1_6, t2_6, t3_6;
  logic [DEN_W-1:0] den6;
  logic [2:0]       neg6;
  side_t            side6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_6  <= {p1h, 33'd0} + NUM_W'(p1l);
      t2_6  <= {p2h, 33'd0} + NUM_W'(p2l);
      t3_6  <= {p3h, 33'd0} + NUM_W'(p3l);
      den6  <= den5;
      neg6  <= neg5;
      side6 <= side5;
    end
  end

  // Stages 7 to 10: signed terms, their sum, and its magnitude.
  logic             v7, v8, v9, v10;
  logic [NUM_W+1:0] st1_7, st2_7, st3_7;
  logic [NUM_W+1:0] n12_8, st3_8;
  logic [NUM_W+1:0] num9;
  logic [NUM_W-1:0] numa10;
  logic             neg10;
  logic [DEN_W-1:0] den7, den8, den9, den10;
  side_t            side7, side8, side9, side10;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7  <= 1'b0;
      v8  <= 1'b0;
      v9  <= 1'b0;
      v10 <= 1'b0;
    end else if (adv) begin
      v7  <= v6;
      v8  <= v7;
      v9  <= v8;
      v10 <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st1_7  <= neg6[0] ? -{2'b00, t1_6} : {2'b00, t1_6};
      st2_7  <= neg6[1] ? -{2'b00, t2_6} : {2'b00, t2_6};
      st3_7  <= neg6[2] ? -{2'b00, t3_6} : {2'b00, t3_6};
      den7   <= den6;
      side7  <= side6;
      n12_8  <= st1_7 + st2_7;
      st3_8  <= st3_7;
      den8   <= den7;
      side8  <= side7;
      num9   <= n12_8 + st3_8;
      den9   <= den8;
      side9  <= side8;
      neg10  <= num9[NUM_W+1];
      numa10 <= NUM_W'(num9[NUM_W+1] ? -num9 : num9);
      den10  <= den9;
      side10 <= side9;
    end
  end

  // Overflow compare, then one quotient bit per stage.
  div_bus_t bus [Q_W+1];
  div_bus_t bus0_next;

  always_comb begin
    bus0_next.valid  = v10;
    bus0_next.last   = side10.last;
    bus0_next.flat   = side10.flat;
    bus0_next.neg    = neg10;
    bus0_next.ov     = CMP_W'(numa10) >= (CMP_W'(den10) << Q_W);
    bus0_next.centre = side10.centre;
    bus0_next.quo    = '0;
    bus0_next.rem    = numa10;
    bus0_next.den    = den10;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bus[0].valid <= 1'b0;
    end else if (adv) begin
      bus[0] <= bus0_next;
    end
  end

  for (genvar i = 0; i < Q_W; i++) begin : g_div
    mcb_div_step #(.BIT(Q_W - 1 - i)) u_step (
      .clk  (clk),
      .rst  (rst),
      .adv  (adv),
      .din  (bus[i]),
      .dout (bus[i+1])
    );
  end

  // Final correction and saturation.
  localparam logic [Q_W-1:0] QMAX = Q_W'(1) << (Q_W - 1);

  logic [Q_W-1:0]    qm;
  logic signed [42:0] sum;
  res_t              fin;

  always_comb begin
    qm  = (bus[Q_W].ov || (bus[Q_W].quo > QMAX)) ? QMAX : bus[Q_W].quo;
    sum = {{11{bus[Q_W].centre[31]}}, bus[Q_W].centre}
          + (bus[Q_W].neg ? -{2'b00, qm} : {2'b00, qm});
    fin.last = bus[Q_W].last;
    if (bus[Q_W].flat) begin
      fin.value = bus[Q_W].centre;
    end else if (sum > 43'sd2147483647) begin
      fin.value = 32'sh7FFF_FFFF;
    end else if (sum < -43'sd2147483648) begin
      fin.value = 32'sh8000_0000;
    end else begin
      fin.value = sum[31:0];
    end
  end

  res_t out_data;

  mcb_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .pipe_valid (bus[Q_W].valid),
    .pipe_data  (fin),
    .skid_full  (skid_full),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_ready  (out_ready)
  );

  assign filtered_value = out_data.value;
  assign last_of_frame  = out_data.last;

endmodule

// ===== rtl/core/mcb_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the blur pass core, bound to the top level.
// Depends on mean_curvature_blur_pass_core_defines.svh.
`include "mean_curvature_blur_pass_core_defines.svh"
module mcb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] filtered_value,
  input logic        last_of_frame,
  input logic        pready
);

  `MCB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(filtered_value) && $stable(last_of_frame))
  `MCB_ASSERT_SAME(a_stall_needs_result, !in_ready, out_valid)
  `MCB_ASSERT_SAME(a_stall_cause, $fell(in_ready), $past(out_valid && !out_ready))
  `MCB_ASSERT_SAME(a_apb_ready, in_valid || !in_valid, pready)

endmodule

bind mean_curvature_blur_pass_core mcb_checker u_mcb_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .filtered_value (filtered_value),
  .last_of_frame  (last_of_frame),
  .pready         (pready)
);
